// ===== rtl/multi_voice_tone_synth_pwm_mixer_defines.svh =====
// Assertion macros for the checker module.
`ifndef MULTI_VOICE_TONE_SYNTH_PWM_MIXER_DEFINES_SVH
`define MULTI_VOICE_TONE_SYNTH_PWM_MIXER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define MVTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define MVTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mvts_pkg.sv =====
package mvts_pkg;

    localparam int VoiceCount = 4;

    localparam int unsigned BoostNum  = 179025;
    localparam int unsigned BoostBase = 430;

    localparam logic [6:0]  SlewMax     = 7'd64;
    localparam logic [9:0]  PwmIdle     = 10'd1023;
    localparam logic [7:0]  LevelCenter = 8'd128;
    localparam logic [7:0]  WaveOffset  = 8'd127;
    localparam logic [7:0]  DutyReset   = 8'd128;
    localparam logic [15:0] Step440Hz   = 16'd1845;

    // Waveform codes; anything above sawtooth is silence
    localparam logic [2:0] ShapeRect = 3'd0;
    localparam logic [2:0] ShapeSine = 3'd1;
    localparam logic [2:0] ShapeTri  = 3'd2;
    localparam logic [2:0] ShapeSaw  = 3'd3;

    localparam logic [7:0] SineRom [256] = '{
        8'd127, 8'd130, 8'd133, 8'd136, 8'd139, 8'd143, 8'd146, 8'd149,
        8'd152, 8'd155, 8'd158, 8'd161, 8'd164, 8'd167, 8'd170, 8'd173,
        8'd176, 8'd179, 8'd182, 8'd184, 8'd187, 8'd190, 8'd193, 8'd195,
        8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd213, 8'd215,
        8'd217, 8'd219, 8'd221, 8'd224, 8'd226, 8'd228, 8'd229, 8'd231,
        8'd233, 8'd235, 8'd236, 8'd238, 8'd239, 8'd241, 8'd242, 8'd244,
        8'd245, 8'd246, 8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd251,
        8'd252, 8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254,
        8'd255, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd253, 8'd253,
        8'd252, 8'd251, 8'd251, 8'd250, 8'd249, 8'd248, 8'd247, 8'd246,
        8'd245, 8'd244, 8'd242, 8'd241, 8'd239, 8'd238, 8'd236, 8'd235,
        8'd233, 8'd231, 8'd229, 8'd228, 8'd226, 8'd224, 8'd221, 8'd219,
        8'd217, 8'd215, 8'd213, 8'd210, 8'd208, 8'd205, 8'd203, 8'd200,
        8'd198, 8'd195, 8'd193, 8'd190, 8'd187, 8'd184, 8'd182, 8'd179,
        8'd176, 8'd173, 8'd170, 8'd167, 8'd164, 8'd161, 8'd158, 8'd155,
        8'd152, 8'd149, 8'd146, 8'd143, 8'd139, 8'd136, 8'd133, 8'd130,
        8'd127, 8'd124, 8'd121, 8'd118, 8'd115, 8'd111, 8'd108, 8'd105,
        8'd102, 8'd99,  8'd96,  8'd93,  8'd90,  8'd87,  8'd84,  8'd81,
        8'd78,  8'd75,  8'd72,  8'd70,  8'd67,  8'd64,  8'd61,  8'd59,
        8'd56,  8'd54,  8'd51,  8'd49,  8'd46,  8'd44,  8'd41,  8'd39,
        8'd37,  8'd35,  8'd33,  8'd30,  8'd28,  8'd26,  8'd25,  8'd23,
        8'd21,  8'd19,  8'd18,  8'd16,  8'd15,  8'd13,  8'd12,  8'd10,
        8'd9,   8'd8,   8'd7,   8'd6,   8'd5,   8'd4,   8'd3,   8'd3,
        8'd2,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,
        8'd2,   8'd3,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,
        8'd9,   8'd10,  8'd12,  8'd13,  8'd15,  8'd16,  8'd18,  8'd19,
        8'd21,  8'd23,  8'd25,  8'd26,  8'd28,  8'd30,  8'd33,  8'd35,
        8'd37,  8'd39,  8'd41,  8'd44,  8'd46,  8'd49,  8'd51,  8'd54,
        8'd56,  8'd59,  8'd61,  8'd64,  8'd67,  8'd70,  8'd72,  8'd75,
        8'd78,  8'd81,  8'd84,  8'd87,  8'd90,  8'd93,  8'd96,  8'd99,
        8'd102, 8'd105, 8'd108, 8'd111, 8'd115, 8'd118, 8'd121, 8'd124
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD,
        ST_MUL,
        ST_ACC,
        ST_SLEW,
        ST_BMUL,
        ST_OUT
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic set_voice;
        logic start_tick;
        logic voice_upd;
        logic mul_sample;
        logic acc;
        logic slew;
        logic mul_boost;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last_voice;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/mvts_ctrl.sv =====
module mvts_ctrl
    import mvts_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_kind,
    input  t_stat i_stat,
    output logic  o_stall,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // Hold the state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Run a tick: per voice update, multiply, accumulate; then slew, boost, output
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    if (i_kind) begin
                        o_cmd.set_voice = 1'b1;
                    end else begin
                        o_cmd.start_tick = 1'b1;
                        n_state          = ST_UPD;
                    end
                end
            end
            ST_UPD: begin
                o_cmd.voice_upd = 1'b1;
                n_state         = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul_sample = 1'b1;
                n_state          = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_stat.last_voice ? ST_SLEW : ST_UPD;
            end
            ST_SLEW: begin
                o_cmd.slew = 1'b1;
                n_state    = ST_BMUL;
            end
            ST_BMUL: begin
                o_cmd.mul_boost = 1'b1;
                n_state         = ST_OUT;
            end
            ST_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/mvts_datapath.sv =====
module mvts_datapath
    import mvts_pkg::*;
#(
    parameter int VOICE_COUNT = VoiceCount
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [1:0]  i_voice_index,
    input  logic [7:0]  i_target_volume,
    input  logic [2:0]  i_wave_shape,
    input  logic [7:0]  i_duty_cycle,
    input  logic [15:0] i_phase_step,
    input  logic        i_stall,
    output t_stat       o_stat,
    output logic        o_valid,
    output logic [9:0]  o_compare_a,
    output logic [9:0]  o_compare_b,
    output logic [7:0]  o_mix_level
);

    localparam int VidxW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

    // Per-voice state
    logic [15:0] r_phase   [VOICE_COUNT];
    logic [7:0]  r_cur_vol [VOICE_COUNT];
    logic [7:0]  r_goal    [VOICE_COUNT];
    logic [2:0]  r_shape_v [VOICE_COUNT];
    logic [7:0]  r_duty_v  [VOICE_COUNT];
    logic [15:0] r_step    [VOICE_COUNT];

    logic [VidxW-1:0] r_voice;
    logic [7:0]       r_total;
    logic [7:0]       r_level;

    // Working registers of the current voice
    logic [7:0]  r_phi;
    logic [7:0]  r_vol;
    logic [2:0]  r_shape;
    logic [7:0]  r_duty;
    logic [15:0] r_prod;

    // Slew results
    logic [6:0]  r_delta;
    logic        r_up;
    logic        r_dn;
    logic [10:0] r_boost;

    logic        r_out_valid;
    logic [9:0]  r_cmp_a;
    logic [9:0]  r_cmp_b;

    logic [10:0]      boost_tab [256];
    logic [VidxW-1:0] set_idx;
    logic             set_ok;
    logic [15:0]      n_phase;
    logic [7:0]       n_vol;
    logic [7:0]       cur_vol;
    logic [7:0]       cur_goal;
    logic signed [7:0]  wave_s;
    logic [6:0]         tri_t;
    logic signed [11:0] mul_a;
    logic signed [8:0]  mul_b;
    logic signed [20:0] mul_p;
    logic [7:0]         half_vol;
    logic [7:0]         sample;
    logic [7:0]         new_level;
    logic [7:0]         diff;
    logic               lvl_up;
    logic               lvl_dn;
    logic [7:0]         boost_idx;
    logic [9:0]         boost_val;

    // Boost table: 179025 / (430 - index), built at elaboration
    for (genvar g = 0; g < 256; g++) begin : g_boost
        localparam int unsigned BoostVal = BoostNum / (BoostBase - g);
        assign boost_tab[g] = BoostVal[10:0];
    end

    assign set_idx = VidxW'(i_voice_index);
    assign set_ok  = 32'(i_voice_index) < 32'(VOICE_COUNT);

    // Advance phase and ramp volume of the current voice
    assign cur_vol  = r_cur_vol[r_voice];
    assign cur_goal = r_goal[r_voice];
    assign n_phase  = r_phase[r_voice] + r_step[r_voice];
    always_comb begin
        n_vol = cur_vol;
        if (cur_vol < cur_goal) begin
            n_vol = cur_vol + 8'd1;
        end else if (cur_vol > cur_goal) begin
            n_vol = cur_vol - 8'd1;
        end
    end

    // Form the signed waveform value from the top phase byte
    assign tri_t = r_phi[7] ? ~r_phi[6:0] : r_phi[6:0];
    always_comb begin
        case (r_shape)
            ShapeSine: wave_s = $signed({~SineRom[r_phi][7], SineRom[r_phi][6:0]});
            ShapeTri:  wave_s = $signed({tri_t, 1'b0} - WaveOffset);
            ShapeSaw:  wave_s = $signed(r_phi - WaveOffset);
            default:   wave_s = '0;
        endcase
    end

    // Share one multiplier between sample scaling and boost scaling
    always_comb begin
        if (i_cmd.mul_boost) begin
            mul_a = $signed({1'b0, r_boost});
            mul_b = $signed({2'b00, r_delta});
        end else begin
            mul_a = $signed({{4{wave_s[7]}}, wave_s});
            mul_b = $signed({1'b0, r_vol});
        end
    end
    assign mul_p = mul_a * mul_b;

    // Pick the voice sample; floor shift by 8 is the product's middle byte
    assign half_vol = {1'b0, r_vol[7:1]};
    always_comb begin
        if (r_vol == 8'd0) begin
            sample = '0;
        end else begin
            case (r_shape)
                ShapeRect: sample = (r_phi < r_duty) ? half_vol : 8'd0 - half_vol;
                ShapeSine, ShapeTri, ShapeSaw: sample = r_prod[15:8];
                default: sample = '0;
            endcase
        end
    end

    // Clip the level move to the slew limit
    assign new_level = LevelCenter + r_total;
    assign lvl_up    = new_level > r_level;
    assign lvl_dn    = new_level < r_level;
    assign diff      = lvl_up ? new_level - r_level : r_level - new_level;
    assign boost_idx = lvl_up ? r_level : ~r_level;
    assign boost_val = r_prod[15:6];

    // Voice state: set-voice writes, tick updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < VOICE_COUNT; v++) begin
                r_phase[v]   <= '0;
                r_cur_vol[v] <= '0;
                r_goal[v]    <= '0;
                r_shape_v[v] <= ShapeRect;
                r_duty_v[v]  <= DutyReset;
                r_step[v]    <= Step440Hz;
            end
        end else begin
            if (i_cmd.set_voice && set_ok) begin
                r_goal[set_idx]    <= i_target_volume;
                r_shape_v[set_idx] <= i_wave_shape;
                r_duty_v[set_idx]  <= i_duty_cycle;
                r_step[set_idx]    <= i_phase_step;
            end
            if (i_cmd.voice_upd) begin
                r_phase[r_voice]   <= n_phase;
                r_cur_vol[r_voice] <= n_vol;
            end
        end
    end

    // Walk the voices, accumulate the mix, move the level and flag the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voice     <= '0;
            r_total     <= '0;
            r_level     <= LevelCenter;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start_tick) begin
                r_voice <= '0;
                r_total <= '0;
            end
            if (i_cmd.acc) begin
                r_total <= r_total + sample;
                if (!o_stat.last_voice) begin
                    r_voice <= r_voice + VidxW'(1);
                end
            end
            if (i_cmd.load_out) begin
                if (r_up) begin
                    r_level <= r_level + {1'b0, r_delta};
                end else if (r_dn) begin
                    r_level <= r_level - {1'b0, r_delta};
                end
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working and output payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.voice_upd) begin
            r_phi   <= n_phase[15:8];
            r_vol   <= n_vol;
            r_shape <= r_shape_v[r_voice];
            r_duty  <= r_duty_v[r_voice];
        end
        if (i_cmd.mul_sample || i_cmd.mul_boost) begin
            r_prod <= mul_p[15:0];
        end
        if (i_cmd.slew) begin
            r_up    <= lvl_up;
            r_dn    <= lvl_dn;
            r_delta <= (diff > {1'b0, SlewMax}) ? SlewMax : diff[6:0];
            r_boost <= boost_tab[boost_idx];
        end
        if (i_cmd.load_out) begin
            r_cmp_a <= r_dn ? PwmIdle - boost_val : PwmIdle;
            r_cmp_b <= r_up ? PwmIdle - boost_val : PwmIdle;
        end
    end

    assign o_stat.last_voice = (r_voice == VidxW'(VOICE_COUNT - 1));
    assign o_stat.out_free   = !r_out_valid || !i_stall;

    assign o_valid     = r_out_valid;
    assign o_compare_a = r_cmp_a;
    assign o_compare_b = r_cmp_b;
    assign o_mix_level = r_level;

endmodule

// ===== rtl/multi_voice_tone_synth_pwm_mixer.sv =====
// Tone synthesizer with VOICE_COUNT voices and a slewed, boosted PWM output.
// A set-voice item (kind 1) is taken while idle and gives no result. A tick
// item (kind 0) walks the voices one at a time through a shared multiplier,
// with update, multiply and accumulate steps per voice, then goes through the
// slew, boost and output load steps. The result is registered at output load,
// and the next item can be taken once the block is idle again. Input is
// stalled while a tick is in work. The result sits in an output register, so
// the next item is taken while it waits; a tick only stalls at its end if the
// previous result has not yet been taken.
module multi_voice_tone_synth_pwm_mixer
    import mvts_pkg::*;
#(
    parameter int VOICE_COUNT = VoiceCount
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [1:0]  i_voice_index,
    input  logic [7:0]  i_target_volume,
    input  logic [2:0]  i_wave_shape,
    input  logic [7:0]  i_duty_cycle,
    input  logic [15:0] i_phase_step,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [9:0]  o_compare_a,
    output logic [9:0]  o_compare_b,
    output logic [7:0]  o_mix_level
);

    t_cmd  cmd;
    t_stat stat;

    // Sequence the tick
    mvts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .i_stat  (stat),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    // Hold voice state and do the arithmetic
    mvts_datapath #(
        .VOICE_COUNT (VOICE_COUNT)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_voice_index   (i_voice_index),
        .i_target_volume (i_target_volume),
        .i_wave_shape    (i_wave_shape),
        .i_duty_cycle    (i_duty_cycle),
        .i_phase_step    (i_phase_step),
        .i_stall         (i_stall),
        .o_stat          (stat),
        .o_valid         (o_valid),
        .o_compare_a     (o_compare_a),
        .o_compare_b     (o_compare_b),
        .o_mix_level     (o_mix_level)
    );

endmodule

// ===== rtl/mvts_check.sv =====
`include "multi_voice_tone_synth_pwm_mixer_defines.svh"

module mvts_check
    import mvts_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_kind,
    input logic [1:0]  i_voice_index,
    input logic [7:0]  i_target_volume,
    input logic [2:0]  i_wave_shape,
    input logic [7:0]  i_duty_cycle,
    input logic [15:0] i_phase_step,
    input logic        o_valid,
    input logic        i_stall,
    input logic [9:0]  o_compare_a,
    input logic [9:0]  o_compare_b,
    input logic [7:0]  o_mix_level
);

    logic in_take;

    assign in_take = i_valid && !o_stall;

    // Hold a stalled result
    `MVTS_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_compare_a) && $stable(o_compare_b) && $stable(o_mix_level), "stalled result changed")

    // Drive at most one direction at a time
    `MVTS_ASSERT_NOW(a_one_side, o_valid, o_compare_a == PwmIdle || o_compare_b == PwmIdle, "both compare values active")

    // Give no result for a set-voice item
    `MVTS_ASSERT_NEXT(a_set_silent, in_take && i_kind && !o_valid, !o_valid, "set-voice item made a result")

    // Stall input while a tick is in work
    `MVTS_ASSERT_NEXT(a_tick_busy, in_take && !i_kind, o_stall, "input taken during a tick")

endmodule

bind multi_voice_tone_synth_pwm_mixer mvts_check u_check (.*);

// ===== sim/tb_top.sv =====
module tb_top;
    import mvts_pkg::*;

    localparam logic KindTick     = 1'b0;
    localparam logic KindSetVoice = 1'b1;

    // Shape codes 4 through 7 all mean a muted voice
    localparam logic [2:0] ShapeMuteLo = 3'd4;
    localparam logic [2:0] ShapeMuteHi = 3'd7;

    localparam int PhaseCount     = 4;
    localparam int RandomPerPhase = 232;
    localparam int DrainCycles    = 40;

    typedef struct {
        logic        kind;
        logic [1:0]  voice;
        logic [7:0]  volume;
        logic [2:0]  shape;
        logic [7:0]  duty;
        logic [15:0] step;
    } synth_item_t;

    typedef struct {
        logic [9:0] cmp_a;
        logic [9:0] cmp_b;
        logic [7:0] level;
    } mix_out_t;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_valid         = 1'b0;
    logic        o_stall;
    logic        i_kind          = 1'b0;
    logic [1:0]  i_voice_index   = 2'd0;
    logic [7:0]  i_target_volume = 8'd0;
    logic [2:0]  i_wave_shape    = 3'd0;
    logic [7:0]  i_duty_cycle    = 8'd0;
    logic [15:0] i_phase_step    = 16'd0;
    logic        o_valid;
    logic        i_stall         = 1'b0;
    logic [9:0]  o_compare_a;
    logic [9:0]  o_compare_b;
    logic [7:0]  o_mix_level;

    // Voice model state
    logic [15:0] ph_acc   [VoiceCount];
    logic [7:0]  cur_vol  [VoiceCount];
    logic [7:0]  goal_vol [VoiceCount];
    logic [2:0]  shape_r  [VoiceCount];
    logic [7:0]  duty_r   [VoiceCount];
    logic [15:0] step_r   [VoiceCount];
    logic [7:0]  level_r;
    int          boost_tbl [256];

    synth_item_t pending_items [$];
    mix_out_t    predicted_mix [$];
    synth_item_t drv_item;
    mix_out_t    got_mix;
    mix_out_t    want_mix;

    bit item_taken    = 1'b0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int queued_count  = 0;
    int taken_count   = 0;
    int tick_count    = 0;
    int set_count     = 0;
    int checked_count = 0;
    int moved_count   = 0;
    int errors        = 0;

    multi_voice_tone_synth_pwm_mixer i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_voice_index  (i_voice_index),
        .i_target_volume(i_target_volume),
        .i_wave_shape   (i_wave_shape),
        .i_duty_cycle   (i_duty_cycle),
        .i_phase_step   (i_phase_step),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_compare_a    (o_compare_a),
        .o_compare_b    (o_compare_b),
        .o_mix_level    (o_mix_level)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Advance one voice by a tick and return its signed sample as 8 bits
    function automatic logic [7:0] voice_sample(int v);
        logic [7:0] vol;
        logic [7:0] phi;
        int         s;
        int         prod;
        ph_acc[v] = ph_acc[v] + step_r[v];
        vol = cur_vol[v];
        if (vol < goal_vol[v]) begin
            vol = vol + 8'd1;
        end else if (vol > goal_vol[v]) begin
            vol = vol - 8'd1;
        end
        cur_vol[v] = vol;
        if (vol == 8'd0) return 8'd0;
        phi = ph_acc[v][15:8];
        case (shape_r[v])
            ShapeRect: begin
                if (phi < duty_r[v]) return vol >> 1;
                return 8'd0 - (vol >> 1);
            end
            ShapeSine: s = int'(SineRom[phi]) - 128;
            ShapeTri: begin
                if (phi < 8'd128) s = 2 * int'(phi) - 127;
                else s = 2 * (255 - int'(phi)) - 127;
            end
            ShapeSaw: begin
                s = int'(phi) - 127;
                if (s > 127) s = s - 256;
            end
            default: return 8'd0;
        endcase
        prod = s * int'(vol);
        return 8'(prod >>> 8);
    endfunction

    // Mix all voices, slew the level and derive the two compare values
    function automatic mix_out_t mix_tick();
        mix_out_t   r;
        logic [7:0] total;
        logic [7:0] new_lvl;
        int         delta;
        int         boost;
        total = 8'd0;
        for (int v = 0; v < VoiceCount; v++) begin
            total = total + voice_sample(v);
        end
        new_lvl = LevelCenter + total;
        r.cmp_a = PwmIdle;
        r.cmp_b = PwmIdle;
        if (new_lvl > level_r) begin
            delta = int'(new_lvl) - int'(level_r);
            if (delta > int'(SlewMax)) delta = int'(SlewMax);
            boost = (boost_tbl[level_r] * delta) >> 6;
            level_r = 8'(int'(level_r) + delta);
            r.cmp_b = 10'(int'(PwmIdle) - boost);
        end else if (new_lvl < level_r) begin
            delta = int'(level_r) - int'(new_lvl);
            if (delta > int'(SlewMax)) delta = int'(SlewMax);
            boost = (boost_tbl[255 - int'(level_r)] * delta) >> 6;
            level_r = 8'(int'(level_r) - delta);
            r.cmp_a = 10'(int'(PwmIdle) - boost);
        end
        r.level = level_r;
        return r;
    endfunction

    task automatic queue_item(logic k, logic [1:0] v, logic [7:0] vol, logic [2:0] sh,
                              logic [7:0] du, logic [15:0] st);
        synth_item_t it;
        it.kind   = k;
        it.voice  = v;
        it.volume = vol;
        it.shape  = sh;
        it.duty   = du;
        it.step   = st;
        pending_items.push_back(it);
        queued_count++;
    endtask

    task automatic queue_ticks(int n);
        repeat (n) queue_item(KindTick, 2'd0, 8'd0, 3'd0, 8'd0, 16'd0);
    endtask

    // Present the next item at the falling edge; hold it while stalled; draw a random output stall
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || item_taken) begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    drv_item = pending_items.pop_front();
                    i_kind          <= drv_item.kind;
                    i_voice_index   <= drv_item.voice;
                    i_target_volume <= drv_item.volume;
                    i_wave_shape    <= drv_item.shape;
                    i_duty_cycle    <= drv_item.duty;
                    i_phase_step    <= drv_item.step;
                    i_valid         <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
        i_stall <= i_rst_n && ($urandom_range(0, 99) < stall_pct);
    end

    // Check results and feed accepted items to the voice model
    always @(posedge i_clk) begin
        item_taken = i_rst_n && i_valid && !o_stall;
        if (i_rst_n && o_valid && !i_stall) begin
            got_mix.cmp_a = o_compare_a;
            got_mix.cmp_b = o_compare_b;
            got_mix.level = o_mix_level;
            if (predicted_mix.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected result: cmp_a %0d cmp_b %0d level %0d",
                             got_mix.cmp_a, got_mix.cmp_b, got_mix.level);
                end
            end else begin
                want_mix = predicted_mix.pop_front();
                checked_count++;
                if (got_mix.cmp_a != want_mix.cmp_a || got_mix.cmp_b != want_mix.cmp_b ||
                    got_mix.level != want_mix.level) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch %0d: want a %0d b %0d lvl %0d, got a %0d b %0d lvl %0d",
                                 checked_count, want_mix.cmp_a, want_mix.cmp_b,
                                 want_mix.level, got_mix.cmp_a, got_mix.cmp_b,
                                 got_mix.level);
                    end
                end
            end
        end
        if (item_taken) begin
            taken_count++;
            if (i_kind == KindSetVoice) begin
                set_count++;
                if (int'(i_voice_index) < VoiceCount) begin
                    goal_vol[i_voice_index] = i_target_volume;
                    shape_r[i_voice_index]  = i_wave_shape;
                    duty_r[i_voice_index]   = i_duty_cycle;
                    step_r[i_voice_index]   = i_phase_step;
                end
            end else begin
                tick_count++;
                want_mix = mix_tick();
                if (want_mix.cmp_a != PwmIdle || want_mix.cmp_b != PwmIdle) moved_count++;
                predicted_mix.push_back(want_mix);
            end
        end
    end

    initial begin
        #4_000_000;
        $display("timeout: %0d of %0d items taken, %0d results pending",
                 taken_count, queued_count, predicted_mix.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int          kind_pick;
        logic [7:0]  vol_pick;
        logic [2:0]  shape_pick;
        logic [15:0] step_pick;

        // Reset state of the voice model
        for (int v = 0; v < VoiceCount; v++) begin
            ph_acc[v]   = 16'd0;
            cur_vol[v]  = 8'd0;
            goal_vol[v] = 8'd0;
            shape_r[v]  = ShapeRect;
            duty_r[v]   = DutyReset;
            step_r[v]   = Step440Hz;
        end
        level_r = LevelCenter;
        for (int i = 0; i < 256; i++) begin
            boost_tbl[i] = int'(BoostNum / (BoostBase - i));
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < PhaseCount; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 76; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 76; end
                default: begin send_idle_pct = 26; stall_pct = 26; end
            endcase
            if (ph == 0) begin
                // All voices quiet: level stays at center, both compares idle
                queue_ticks(1);
                // Field extremes and each waveform
                queue_item(KindSetVoice, 2'd0, 8'd255, ShapeRect, 8'd255, 16'hFFFF);
                queue_item(KindSetVoice, 2'd1, 8'd255, ShapeSine, 8'd0, 16'h0000);
                queue_item(KindSetVoice, 2'd2, 8'd200, ShapeTri, 8'h55, 16'h8000);
                queue_item(KindSetVoice, 2'd3, 8'd255, ShapeSaw, 8'hAA, 16'h0100);
                queue_ticks(8);
                // Mute a loud voice through a silent shape code
                queue_item(KindSetVoice, 2'd1, 8'd255, ShapeMuteHi, 8'd1, 16'h7FFF);
                queue_ticks(2);
                // Ramp a voice down; phase and volume carry over the update
                queue_item(KindSetVoice, 2'd0, 8'd0, ShapeRect, 8'd0, 16'h5555);
                queue_ticks(4);
                queue_item(KindSetVoice, 2'd3, 8'd1, ShapeMuteLo, 8'd128, 16'hFFFF);
                queue_ticks(2);
            end
            // Random ticks with voice updates mixed in
            repeat (RandomPerPhase) begin
                kind_pick = $urandom_range(0, 99);
                case ($urandom_range(0, 19))
                    0, 1, 2:  vol_pick = 8'd0;
                    3, 4, 5, 6, 7: vol_pick = 8'($urandom_range(0, 255));
                    default:  vol_pick = 8'($urandom_range(128, 255));
                endcase
                if ($urandom_range(0, 9) < 8) begin
                    shape_pick = 3'($urandom_range(ShapeRect, ShapeSaw));
                end else begin
                    shape_pick = 3'($urandom_range(ShapeMuteLo, ShapeMuteHi));
                end
                case ($urandom_range(0, 9))
                    0:       step_pick = 16'h0000;
                    1:       step_pick = 16'hFFFF;
                    2, 3:    step_pick = 16'($urandom_range(0, 1023));
                    default: step_pick = 16'($urandom_range(0, 65535));
                endcase
                queue_item((kind_pick < 22) ? KindSetVoice : KindTick,
                           2'($urandom_range(0, 3)), vol_pick, shape_pick,
                           8'($urandom_range(0, 255)), step_pick);
            end
            // Drain before the next idling pattern
            while (taken_count != queued_count || predicted_mix.size() != 0) begin
                @(posedge i_clk);
            end
        end

        send_idle_pct = 0;
        stall_pct = 0;
        repeat (DrainCycles) @(posedge i_clk);
        errors += predicted_mix.size();

        $display("covered %0d ticks and %0d voice updates in %0d idling phases",
                 tick_count, set_count, PhaseCount);
        $display("compared %0d results, %0d of them with the level moving",
                 checked_count, moved_count);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
